// ===== hw/rtl/tgr_pkg.sv =====
// Shared types and constants of the text glyph rasterizer.
package tgr_pkg;

   localparam int LINE_W  = 14;  // screen line number of a glyph row
   localparam int PX_W    = 13;  // pixel column of a cell's left edge
   localparam int PXOFF_W = 15;  // byte offset of a cell's left edge
   localparam int PROD_W  = 29;  // line number times line pitch
   localparam int DY_W    = 4;   // row counter within one command
   localparam int MAX_ROWS = 16;

   localparam logic [15:0] GLYPH_QMARK = 16'h003F;
   localparam logic [31:0] PIX24_MASK  = 32'h00FF_FFFF;

   localparam logic [1:0] OP_DRAW   = 2'd0;
   localparam logic [1:0] OP_CURSOR = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PITCH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_MODE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_COLOR  = 3'd5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] char_code;
      logic [9:0]  cell_column;
      logic [8:0]  cell_row;
      logic [31:0] fg_color;
      logic [31:0] bg_color;
      logic [3:0]  glyph_line;
      logic [7:0]  glyph_bits;
   } req_type;

   typedef struct packed {
      logic [31:0] write_address;
      logic [31:0] pixel0;
      logic [31:0] pixel1;
      logic [31:0] pixel2;
      logic [31:0] pixel3;
      logic [31:0] pixel4;
      logic [31:0] pixel5;
      logic [31:0] pixel6;
      logic [31:0] pixel7;
      logic [7:0]  pixel_enable;
      logic        last_row;
   } rsp_type;

   typedef struct packed {
      logic [31:0] frame_base;
      logic [14:0] line_pitch;
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic        pixel_mode;
      logic [31:0] cursor_color;
   } cfg_type;

   // One glyph row on its way from the sequencer to the formatter.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic               cursor;
      logic [PROD_W-1:0]  prod;
      logic [PX_W-1:0]    px;
      logic [PXOFF_W-1:0] px_off;
      logic [31:0]        fg;
      logic [31:0]        bg;
   } row_ctl_type;

endpackage

// ===== hw/rtl/tgr_csr.sv =====
// Configuration registers of the text glyph rasterizer.
module tgr_csr
   import tgr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_write_data,
   output cfg_type              cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_base    <= 32'd0;
         cfg_ff.line_pitch    <= 15'd4096;
         cfg_ff.screen_width  <= 13'd1024;
         cfg_ff.screen_height <= 13'd768;
         cfg_ff.pixel_mode    <= 1'b1;
         cfg_ff.cursor_color  <= PIX24_MASK;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_BASE:    cfg_ff.frame_base    <= csr_write_data;
            CSR_LINE_PITCH:    cfg_ff.line_pitch    <= csr_write_data[14:0];
            CSR_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_write_data[12:0];
            CSR_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_write_data[12:0];
            CSR_PIXEL_MODE:    cfg_ff.pixel_mode    <= csr_write_data[0];
            CSR_CURSOR_COLOR:  cfg_ff.cursor_color  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/tgr_glyph_mem.sv =====
// Glyph store: one byte per glyph row, registered read.
module tgr_glyph_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tgr_row_seq.sv =====
// Command sequencer: takes commands, writes glyph rows, steps through rows to draw.
module tgr_row_seq
   import tgr_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 16,
   parameter int GLYPH_COUNT  = 256,
   parameter int AW           = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  req_type       req,
   input  cfg_type       cfg,
   output logic          busy,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic [7:0]    mem_wdata,
   output logic          mem_re,
   output logic [AW-1:0] mem_raddr,
   output row_ctl_type   ctl
);

   localparam int GIW  = $clog2(GLYPH_COUNT);
   localparam int ROWS = (GLYPH_HEIGHT < MAX_ROWS) ? GLYPH_HEIGHT : MAX_ROWS;
   localparam logic [DY_W-1:0]   DRAW_LAST     = DY_W'(ROWS - 1);
   localparam logic [DY_W-1:0]   CURSOR_LAST   = DY_W'(GLYPH_HEIGHT / 8 - 1);
   localparam logic [LINE_W-1:0] CURSOR_OFFSET = LINE_W'(GLYPH_HEIGHT * 13 / 16);

   typedef enum logic {S_IDLE, S_RUN} state_type;

   state_type          state_ff;
   logic [AW-1:0]      gbase_ff;
   logic [LINE_W-1:0]  line_ff;
   logic [DY_W-1:0]    dy_ff;
   logic [DY_W-1:0]    dy_last_ff;
   logic               cursor_ff;
   logic [PX_W-1:0]    px_ff;
   logic [PXOFF_W-1:0] px_off_ff;
   logic [31:0]        fg_ff;
   logic [31:0]        bg_ff;
   row_ctl_type        ctl_ff;

   logic               accept;
   logic               code_ok;
   logic [GIW-1:0]     glyph;
   logic [LINE_W-1:0]  cell_line;
   logic [PX_W-1:0]    px_in;
   logic [PXOFF_W-1:0] px_off_in;
   logic               line_ok;
   logic               row_last;

   always_comb begin
      accept    = start && (state_ff == S_IDLE);
      code_ok   = {1'b0, req.char_code} < 17'(GLYPH_COUNT);
      glyph     = code_ok ? req.char_code[GIW-1:0] : GLYPH_QMARK[GIW-1:0];
      cell_line = LINE_W'(req.cell_row) * LINE_W'(GLYPH_HEIGHT);
      px_in     = PX_W'(req.cell_column) * PX_W'(GLYPH_WIDTH);
      px_off_in = cfg.pixel_mode ? {px_in, 2'b00}
                                 : ({1'b0, px_in, 1'b0} + {2'b00, px_in});
      line_ok   = line_ff < {1'b0, cfg.screen_height};
      // The command ends on its last row or on the last visible screen line.
      row_last  = (dy_ff == dy_last_ff) ||
                  (({1'b0, line_ff} + 15'd1) >= {2'b00, cfg.screen_height});
   end

   // Loads happen only while idle and reads only while running, so the two
   // ports never touch the store in the same cycle.
   assign mem_we    = accept && (req.operation == OP_LOAD) && code_ok &&
                      ({2'b00, req.glyph_line} < 6'(GLYPH_HEIGHT));
   assign mem_waddr = AW'(glyph) * AW'(GLYPH_HEIGHT) + AW'(req.glyph_line);
   assign mem_wdata = req.glyph_bits;
   assign mem_re    = (state_ff == S_RUN) && !cursor_ff;
   assign mem_raddr = gbase_ff + AW'(dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ctl_ff.valid <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               ctl_ff.valid <= 1'b0;
               if (accept) begin
                  gbase_ff  <= AW'(glyph) * AW'(GLYPH_HEIGHT);
                  dy_ff     <= '0;
                  px_ff     <= px_in;
                  px_off_ff <= px_off_in;
                  unique case (req.operation)
                     OP_DRAW: begin
                        state_ff   <= S_RUN;
                        line_ff    <= cell_line;
                        dy_last_ff <= DRAW_LAST;
                        cursor_ff  <= 1'b0;
                        fg_ff      <= req.fg_color;
                        bg_ff      <= req.bg_color;
                     end
                     OP_CURSOR: begin
                        state_ff   <= S_RUN;
                        line_ff    <= cell_line + CURSOR_OFFSET;
                        dy_last_ff <= CURSOR_LAST;
                        cursor_ff  <= 1'b1;
                        fg_ff      <= cfg.cursor_color;
                        bg_ff      <= cfg.cursor_color;
                     end
                     default: ;
                  endcase
               end
            end
            S_RUN: begin
               ctl_ff.valid  <= line_ok;
               ctl_ff.last   <= row_last;
               ctl_ff.cursor <= cursor_ff;
               ctl_ff.prod   <= PROD_W'(line_ff) * PROD_W'(cfg.line_pitch);
               ctl_ff.px     <= px_ff;
               ctl_ff.px_off <= px_off_ff;
               ctl_ff.fg     <= fg_ff;
               ctl_ff.bg     <= bg_ff;
               if (!line_ok || row_last) begin
                  state_ff <= S_IDLE;
               end else begin
                  dy_ff   <= dy_ff + 1'b1;
                  line_ff <= line_ff + 1'b1;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               ctl_ff.valid <= 1'b0;
            end
         endcase
      end
   end

   assign busy = (state_ff == S_RUN);
   assign ctl  = ctl_ff;

endmodule

// ===== hw/rtl/tgr_row_fmt.sv =====
// Row formatter: builds the write address and pixel colours of one glyph row.
module tgr_row_fmt
   import tgr_pkg::*;
#(
   parameter int GLYPH_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  row_ctl_type ctl,
   input  logic [7:0]  rd_data,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   logic        valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic [7:0]  bits;
   logic [7:0]  aligned;
   logic [7:0]  en;
   logic [31:0] color;
   logic [31:0] pix [8];

   always_comb begin
      bits = ctl.cursor ? 8'hFF : rd_data;
      // Left-justify the glyph so pixel i always reads bit 7-i.
      aligned = 8'(bits << (8 - GLYPH_WIDTH));
      for (int i = 0; i < 8; i++) begin
         en[i] = (i < GLYPH_WIDTH) &&
                 (({1'b0, ctl.px} + 14'(i)) < {1'b0, cfg.screen_width});
         color = aligned[7 - i] ? ctl.fg : ctl.bg;
         if (!cfg.pixel_mode) begin
            color = color & PIX24_MASK;
         end
         pix[i] = en[i] ? color : 32'd0;
      end
      rsp_in.write_address = cfg.frame_base + 32'(ctl.prod) + 32'(ctl.px_off);
      rsp_in.pixel0        = pix[0];
      rsp_in.pixel1        = pix[1];
      rsp_in.pixel2        = pix[2];
      rsp_in.pixel3        = pix[3];
      rsp_in.pixel4        = pix[4];
      rsp_in.pixel5        = pix[5];
      rsp_in.pixel6        = pix[6];
      rsp_in.pixel7        = pix[7];
      rsp_in.pixel_enable  = en;
      rsp_in.last_row      = ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== hw/rtl/text_glyph_rasterizer.sv =====
// Top level of the text glyph rasterizer.
//
// Commands come in on req_* and are taken at a clock edge where start is high
// and busy is low. A load command writes one glyph row into the glyph store;
// busy stays low. A draw or cursor command raises busy and steps one row per
// cycle, at most 16 rows at the default glyph height and 2 for the cursor,
// and stops at the last visible screen line. Only a draw command reads the
// glyph store, once per row. The next command can be taken in the cycle
// after the last row is stepped. Each row word appears on rsp_* for one
// cycle with rsp_valid high. A row word is registered in the sequencer's ctl
// register, next to the glyph store read, and then in the formatter's output
// register; words follow one per cycle, and rsp.last_row marks the final word.
// The receiver cannot stall. Configuration must be written through csr_*
// only while the block is idle; the block itself does not enforce this.
// Reset restores the register defaults and clears busy and rsp_valid; glyph
// store contents are undefined until loaded.
module text_glyph_rasterizer
   import tgr_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 16,
   parameter int GLYPH_COUNT  = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req,
   output logic                 rsp_valid,
   output rsp_type              rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_write_data
);

   localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int AW    = $clog2(DEPTH);

   cfg_type       cfg;
   row_ctl_type   ctl;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    mem_rdata;

   tgr_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   tgr_row_seq #(
      .GLYPH_WIDTH  (GLYPH_WIDTH),
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT),
      .AW           (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .cfg       (cfg),
      .busy      (busy),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .ctl       (ctl)
   );

   tgr_glyph_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   tgr_row_fmt #(
      .GLYPH_WIDTH (GLYPH_WIDTH)
   ) u_fmt (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctl       (ctl),
      .rd_data   (mem_rdata),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

endmodule

// ===== hw/rtl/tgr_checker.sv =====
// Port-level checks of the text glyph rasterizer and their binding.
module tgr_checker
   import tgr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req,
   input logic    rsp_valid,
   input rsp_type rsp
);

   // Reset leaves the block idle with no word on the result port.
   assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // A glyph load finishes in the cycle it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.operation == OP_LOAD) |=> !busy)
      else $error("load command made the block busy");

   // Every row word comes from a row that a running command stepped, through ctl and the formatter register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy, 2))
      else $error("row word without a running command");

   // The next command's first word cannot follow a final word directly.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp.last_row) |=> !rsp_valid)
      else $error("row word right after the final word");

   // Clipped pixels carry no colour; pixel 0 and pixel 7 are checked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp.pixel_enable[0] || rsp.pixel0 == 32'd0) &&
                     (rsp.pixel_enable[7] || rsp.pixel7 == 32'd0)))
      else $error("clipped pixel carries a colour");

endmodule

bind text_glyph_rasterizer tgr_checker u_tgr_checker (.*);

// ===== test/text_glyph_rasterizer_tb.sv =====
// Self-checking testbench for the text glyph rasterizer: directed and random commands.
`timescale 1ns / 100ps

module text_glyph_rasterizer_tb;
   import tgr_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int GLYPH_W     = 8;
   localparam int GLYPH_H     = 16;
   localparam int GLYPH_N     = 256;
   localparam int CURSOR_OFFSET = 13;
   localparam int CURSOR_ROWS = 2;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 40;
   localparam logic [1:0] OP_NONE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req = '0;
   logic                 rsp_valid;
   rsp_type              rsp;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_write_data = '0;

   text_glyph_rasterizer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req              (req),
      .rsp_valid        (rsp_valid),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Register values after reset.
   cfg_type shadow_cfg = '{frame_base: 32'd0, line_pitch: 15'd4096, screen_width: 13'd1024,
                           screen_height: 13'd768, pixel_mode: 1'b1,
                           cursor_color: 32'h00FF_FFFF};

   rsp_type    expected_rows[$];
   logic [7:0] glyph_rows [0:GLYPH_N*GLYPH_H-1];
   bit         row_loaded [0:GLYPH_N*GLYPH_H-1];
   bit         glyph_ready [0:GLYPH_N-1];
   int         ready_codes[$];
   int         idle_pct = 0;
   int         useful_words = 0;
   int         mismatch_count = 0;
   int         idle_cycles = 0;

   function automatic rsp_type make_row(logic [31:0] line, logic [31:0] px, logic [7:0] bits,
                                        logic [31:0] fg, logic [31:0] bg);
      logic [0:7][31:0] pix;
      logic [7:0]       en;
      logic [31:0]      stride;
      logic [31:0]      addr;
      pix = '0;
      en = '0;
      stride = shadow_cfg.pixel_mode ? 32'd4 : 32'd3;
      addr = shadow_cfg.frame_base + line * 32'(shadow_cfg.line_pitch) + px * stride;
      for (int i = 0; i < GLYPH_W; i++) begin
         if (px + i < 32'(shadow_cfg.screen_width)) begin
            pix[i] = bits[GLYPH_W-1-i] ? fg : bg;
            if (!shadow_cfg.pixel_mode) pix[i] &= PIX24_MASK;
            en[i] = 1'b1;
         end
      end
      return {addr, pix, en, 1'b0};
   endfunction

   // Updates the glyph store copy and queues every row word the command produces.
   task automatic rasterize_word(req_type w);
      rsp_type     rows[$];
      logic [31:0] px;
      logic [31:0] py;
      int          glyph;
      int          slot;
      bit          complete;
      px = 32'(w.cell_column) * GLYPH_W;
      py = 32'(w.cell_row) * GLYPH_H;
      case (w.operation)
         OP_LOAD: begin
            if (w.char_code < GLYPH_N) begin
               slot = w.char_code * GLYPH_H + w.glyph_line;
               glyph_rows[slot] = w.glyph_bits;
               row_loaded[slot] = 1'b1;
               complete = 1'b1;
               for (int dy = 0; dy < GLYPH_H; dy++)
                  complete &= row_loaded[w.char_code * GLYPH_H + dy];
               if (complete && !glyph_ready[w.char_code]) begin
                  glyph_ready[w.char_code] = 1'b1;
                  ready_codes.push_back(w.char_code);
               end
               useful_words++;
            end
         end
         OP_DRAW: begin
            glyph = (w.char_code < GLYPH_N) ? w.char_code : GLYPH_QMARK;
            for (int dy = 0; dy < GLYPH_H; dy++) begin
               if (py + dy >= 32'(shadow_cfg.screen_height)) break;
               rows.push_back(make_row(py + dy, px, glyph_rows[glyph * GLYPH_H + dy],
                                       w.fg_color, w.bg_color));
            end
            useful_words++;
         end
         OP_CURSOR: begin
            for (int dy = 0; dy < CURSOR_ROWS; dy++) begin
               if (py + CURSOR_OFFSET + dy >= 32'(shadow_cfg.screen_height)) break;
               rows.push_back(make_row(py + CURSOR_OFFSET + dy, px, 8'hFF,
                                       shadow_cfg.cursor_color, shadow_cfg.cursor_color));
            end
            useful_words++;
         end
         default: ;
      endcase
      if (rows.size() != 0) rows[rows.size()-1].last_row = 1'b1;
      foreach (rows[k]) expected_rows.push_back(rows[k]);
   endtask

   function automatic req_type scrambled_word();
      req_type w;
      w.operation   = 2'($urandom);
      w.char_code   = 16'($urandom);
      w.cell_column = 10'($urandom);
      w.cell_row    = 9'($urandom);
      w.fg_color    = $urandom;
      w.bg_color    = $urandom;
      w.glyph_line  = 4'($urandom);
      w.glyph_bits  = 8'($urandom);
      return w;
   endfunction

   function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi);
      case ($urandom_range(7))
         0: return lo;
         1: return hi;
         default: return (hi == 32'hFFFF_FFFF) ? $urandom : $urandom_range(hi, lo);
      endcase
   endfunction

   task automatic send_word(req_type w);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      rasterize_word(w);
   endtask

   task automatic send_cell(logic [1:0] op, logic [15:0] code, logic [9:0] col, logic [8:0] row);
      req_type w;
      w = scrambled_word();
      w.operation = op;
      w.char_code = code;
      w.cell_column = col;
      w.cell_row = row;
      send_word(w);
   endtask

   // Holds the sender off until every queued row word has come back and the block is quiet.
   task automatic settle();
      start <= 1'b0;
      while (expected_rows.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic program_regs(cfg_type c);
      put_reg(CSR_FRAME_BASE, c.frame_base);
      put_reg(CSR_LINE_PITCH, 32'(c.line_pitch));
      put_reg(CSR_SCREEN_WIDTH, 32'(c.screen_width));
      put_reg(CSR_SCREEN_HEIGHT, 32'(c.screen_height));
      put_reg(CSR_PIXEL_MODE, 32'(c.pixel_mode));
      put_reg(CSR_CURSOR_COLOR, c.cursor_color);
      csr_write_enable <= 1'b0;
      shadow_cfg = c;
   endtask

   task automatic test_default_regs();
      req_type w;
      idle_pct = 0;
      // Codes without a glyph fall back to '?', so that glyph is loaded first.
      for (int line = 0; line < GLYPH_H; line++) begin
         w = scrambled_word();
         w.operation = OP_LOAD;
         w.char_code = GLYPH_QMARK;
         w.glyph_line = line[3:0];
         case (line)
            0: w.glyph_bits = 8'h00;
            1: w.glyph_bits = 8'hFF;
            2: w.glyph_bits = 8'h80;
            3: w.glyph_bits = 8'h01;
            default: ;
         endcase
         send_word(w);
      end
      w = scrambled_word();
      w.operation = OP_LOAD;
      w.char_code = 16'hFFFF;
      send_word(w);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd0, 9'd0);
      send_cell(OP_DRAW, 16'hFFFF, 10'd127, 9'd47);
      send_cell(OP_DRAW, 16'h0100, 10'd128, 9'd47);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd1023, 9'd48);
      send_cell(OP_CURSOR, 16'h0000, 10'd0, 9'd0);
      send_cell(OP_CURSOR, 16'hFFFF, 10'd1023, 9'd511);
      send_cell(OP_NONE, 16'($urandom), 10'd0, 9'd0);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd64, 9'd20);
   endtask

   task automatic test_register_extremes();
      cfg_type c;
      settle();
      c = '{frame_base: 32'hFFFF_FFFF, line_pitch: 15'd16384, screen_width: 13'd0,
            screen_height: 13'd4096, pixel_mode: 1'b0, cursor_color: 32'hFFFF_FFFF};
      program_regs(c);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd0, 9'd255);
      send_cell(OP_CURSOR, 16'h0000, 10'd1023, 9'd0);
      settle();
      c = '{frame_base: 32'd0, line_pitch: 15'd0, screen_width: 13'd4096,
            screen_height: 13'd0, pixel_mode: 1'b1, cursor_color: 32'd0};
      program_regs(c);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd0, 9'd0);
      send_cell(OP_CURSOR, 16'h0000, 10'd0, 9'd0);
      settle();
      // The bottom cell row and the right cell column are only partly visible here.
      c = '{frame_base: $urandom, line_pitch: 15'd16383, screen_width: 13'd4093,
            screen_height: 13'd4094, pixel_mode: 1'b0, cursor_color: $urandom};
      program_regs(c);
      send_cell(OP_DRAW, 16'h8000, 10'd511, 9'd255);
      send_cell(OP_CURSOR, 16'h0000, 10'd511, 9'd255);
      send_cell(OP_DRAW, GLYPH_QMARK, 10'd512, 9'd0);
   endtask

   task automatic random_step();
      int         pick;
      int         code;
      logic [9:0] col;
      logic [8:0] row;
      req_type    w;
      pick = $urandom_range(99);
      col = ($urandom_range(3) == 0) ? 10'($urandom)
                                     : 10'($urandom_range(0, shadow_cfg.screen_width / GLYPH_W));
      row = ($urandom_range(3) == 0) ? 9'($urandom)
                                     : 9'($urandom_range(0, shadow_cfg.screen_height / GLYPH_H));
      if (pick < 5) begin
         case ($urandom_range(7))
            0: code = 0;
            1: code = GLYPH_N - 1;
            default: code = $urandom_range(0, GLYPH_N - 1);
         endcase
         for (int line = 0; line < GLYPH_H; line++) begin
            w = scrambled_word();
            w.operation = OP_LOAD;
            w.char_code = 16'(code);
            w.glyph_line = line[3:0];
            if ($urandom_range(7) == 0) w.glyph_bits = $urandom_range(1) ? 8'hFF : 8'h00;
            send_word(w);
         end
      end else if (pick < 13) begin
         // Roughly half of these land outside the glyph store and must leave it untouched.
         w = scrambled_word();
         w.operation = OP_LOAD;
         if ($urandom_range(1)) w.char_code = 16'($urandom_range(0, GLYPH_N - 1));
         send_word(w);
      end else if (pick < 17) begin
         send_cell(OP_NONE, 16'($urandom), col, row);
      end else if (pick < 35) begin
         send_cell(OP_CURSOR, 16'($urandom), col, row);
      end else begin
         if ($urandom_range(4) == 0) code = $urandom_range(GLYPH_N, 65535);
         else code = ready_codes[$urandom_range(0, ready_codes.size() - 1)];
         send_cell(OP_DRAW, 16'(code), col, row);
      end
   endtask

   task automatic test_random_traffic();
      cfg_type c;
      int      target;
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         c.frame_base = pick_value(32'd0, 32'hFFFF_FFFF);
         c.line_pitch = 15'(pick_value(32'd0, 32'd16384));
         c.screen_width = 13'(pick_value(32'd1, 32'd4096));
         c.screen_height = 13'(pick_value(32'd1, 32'd4096));
         c.pixel_mode = 1'($urandom_range(1));
         c.cursor_color = pick_value(32'd0, 32'hFFFF_FFFF);
         program_regs(c);
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 52;
            default: idle_pct = 27;
         endcase
         target = useful_words + WORDS_PER_PHASE;
         while (useful_words < target) random_step();
      end
   endtask

   task automatic note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %h, got %h", what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_type          want;
      logic [31:0]      ea, ga;
      logic [0:7][31:0] ep, gp;
      logic [7:0]       ee, ge;
      logic             el, gl;
      if (!reset && rsp_valid) begin
         if (expected_rows.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word with write_address %h", rsp.write_address);
         end else begin
            want = expected_rows.pop_front();
            {ea, ep, ee, el} = want;
            {ga, gp, ge, gl} = rsp;
            if (ga !== ea) note_mismatch("write_address", ea, ga);
            for (int i = 0; i < 8; i++)
               if (gp[i] !== ep[i]) note_mismatch($sformatf("pixel%0d", i), ep[i], gp[i]);
            if (ge !== ee) note_mismatch("pixel_enable", 32'(ee), 32'(ge));
            if (gl !== el) note_mismatch("last_row", 32'(el), 32'(gl));
         end
      end
   end

   // Ends the run when neither a command, a row word nor a register write moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("text_glyph_rasterizer regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_default_regs();
      test_register_extremes();
      test_random_traffic();
      settle();
      repeat (32) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("text_glyph_rasterizer regression: pass");
      end else begin
         $display("text_glyph_rasterizer regression: fail");
      end
      $finish;
   end

endmodule
